[src/stc_pkg.sv]
package stc_pkg;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 30;
   localparam int ScaleWidth    = 30;
   localparam int PixWidth      = 16;
   localparam int ProdWidth     = PixWidth + ScaleWidth;
   localparam int PktBytes      = 5;
   localparam int PktIdxWidth   = $clog2(PktBytes);
   localparam int BufDepth      = 4;
   localparam int LenWidth      = 3;

   localparam logic [CsrIndexWidth-1:0] CSR_DISPLAY_HEIGHT = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_X_SCALE        = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_Y_SCALE        = 2'd2;

   localparam logic [1:0] MODE_HOST  = 2'd0;
   localparam logic [1:0] MODE_TOUCH = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   localparam logic [7:0] TERM_BYTE   = 8'h0d;
   localparam logic [7:0] SOH_BYTE    = 8'h01;
   localparam logic [7:0] CMD_RESTART = 8'h52;
   localparam logic [7:0] CMD_DIAG    = 8'h44;
   localparam logic [7:0] CMD_DIAG_X  = 8'h58;
   localparam logic [7:0] ACK_MID     = 8'h30;
   localparam logic [7:0] HEAD_PRESS  = 8'hc0;
   localparam logic [7:0] HEAD_LIFT   = 8'h80;

   localparam logic [LenWidth-1:0]    LEN_MAX      = 3'd7;
   localparam logic [PktIdxWidth-1:0] ACK_LAST     = 3'd2;
   localparam logic [PktIdxWidth-1:0] REPORT_LAST  = 3'd4;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  host_byte;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic        touch_down;
   } stc_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } stc_rsp_type;

   typedef struct packed {
      logic [PktBytes-1:0][7:0]  bytes;
      logic [PktIdxWidth-1:0]    last_idx;
   } stc_pkt_type;

   typedef struct packed {
      logic       pressed;
      logic       lift_pending;
      logic [15:0] coord_x;
      logic [15:0] coord_y;
   } stc_touch_type;

endpackage

[src/serial_touch_controller.sv]
// flow: an accepted beat is registered in req_ff and processed from there; its first
// result beat is registered in the tx slot, and a busy slot stalls the request
// throughput: a request beat every cycle while no result is owed; an acknowledge takes 3
// result beats and a report 5, and a request owing results waits for the final beat to leave
// reset: synchronous; clears flags, coordinates, command length and config registers
module serial_touch_controller
   import stc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  stc_req_type              req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output stc_rsp_type              rsp_data,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data
);

   stc_req_type   req_ff;
   logic          req_valid_ff, req_valid_in;
   logic          advance;
   logic          needs_out;
   logic          is_host, is_touch, is_tick, is_term;
   logic          booted;
   logic          tx_free;
   logic          report;
   stc_touch_type status;
   stc_pkt_type   pkt;

   assign is_host  = (req_ff.mode == MODE_HOST);
   assign is_touch = (req_ff.mode == MODE_TOUCH);
   assign is_tick  = (req_ff.mode == MODE_TICK);
   assign is_term  = (req_ff.host_byte == TERM_BYTE);
   assign report   = is_tick && (status.pressed || status.lift_pending);

   assign needs_out = (is_host && is_term) || report;
   assign advance   = req_valid_ff && (!needs_out || tx_free);
   assign req_stall = req_valid_ff && !advance;

   assign req_valid_in = req_stall ? req_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_ff <= req_data;
      end
   end

   stc_cmd u_cmd (
      .clock     (clock),
      .reset     (reset),
      .take      (advance && is_host),
      .host_byte (req_ff.host_byte),
      .booted    (booted)
   );

   stc_touch u_touch (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .touch_take (advance && is_touch && booted),
      .tick_take  (advance && is_tick),
      .pos_x      (req_ff.pos_x),
      .pos_y      (req_ff.pos_y),
      .touch_down (req_ff.touch_down),
      .status     (status)
   );

   // the report snapshots coordinates so later touches cannot alter it in flight
   always_comb begin
      if (is_tick) begin
         pkt.bytes[0]  = status.pressed ? HEAD_PRESS : HEAD_LIFT;
         pkt.bytes[1]  = {1'b0, status.coord_x[6:0]};
         pkt.bytes[2]  = {1'b0, status.coord_x[13:7]};
         pkt.bytes[3]  = {1'b0, status.coord_y[6:0]};
         pkt.bytes[4]  = {1'b0, status.coord_y[13:7]};
         pkt.last_idx  = REPORT_LAST;
      end else begin
         pkt.bytes[0]  = SOH_BYTE;
         pkt.bytes[1]  = ACK_MID;
         pkt.bytes[2]  = TERM_BYTE;
         pkt.bytes[3]  = '0;
         pkt.bytes[4]  = '0;
         pkt.last_idx  = ACK_LAST;
      end
   end

   stc_tx u_tx (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && needs_out),
      .pkt       (pkt),
      .rsp_stall (rsp_stall),
      .free      (tx_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

[src/stc_cmd.sv]
module stc_cmd
   import stc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] host_byte,
   output logic       booted
);

   logic [BufDepth-1:0][7:0] cmd_buffer_ff;
   logic [LenWidth-1:0]      cmd_length_ff, cmd_length_in;
   logic                     booted_ff, booted_in;
   logic                     is_term;
   logic                     match_reset, match_diag;

   assign is_term = (host_byte == TERM_BYTE);

   assign match_reset = (cmd_length_ff == 3'd2) && (cmd_buffer_ff[0] == SOH_BYTE) &&
                        (cmd_buffer_ff[1] == CMD_RESTART);
   assign match_diag  = (cmd_length_ff == 3'd3) && (cmd_buffer_ff[0] == SOH_BYTE) &&
                        (cmd_buffer_ff[1] == CMD_DIAG) && (cmd_buffer_ff[2] == CMD_DIAG_X);

   always_comb begin
      cmd_length_in = cmd_length_ff;
      booted_in     = booted_ff;
      if (take) begin
         if (is_term) begin
            cmd_length_in = '0;
            if (match_reset) begin
               booted_in = 1'b0;
            end else if (match_diag) begin
               booted_in = 1'b1;
            end
         end else if (cmd_length_ff != LEN_MAX) begin
            cmd_length_in = cmd_length_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_length_ff <= '0;
         booted_ff     <= 1'b0;
      end else begin
         cmd_length_ff <= cmd_length_in;
         booted_ff     <= booted_in;
      end
   end

   // bytes past the fourth are counted but not kept
   always_ff @(posedge clock) begin
      if (take && !is_term && !cmd_length_ff[2]) begin
         cmd_buffer_ff[cmd_length_ff[1:0]] <= host_byte;
      end
   end

   assign booted = booted_ff;

endmodule

[src/stc_touch.sv]
module stc_touch
   import stc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   input  logic                     touch_take,
   input  logic                     tick_take,
   input  logic [15:0]              pos_x,
   input  logic [15:0]              pos_y,
   input  logic                     touch_down,
   output stc_touch_type            status
);

   logic [15:0]           display_height_ff;
   logic [ScaleWidth-1:0] x_scale_ff, y_scale_ff;
   logic                  pressed_ff, pressed_in;
   logic                  lift_pending_ff, lift_pending_in;
   logic [15:0]           coord_x_ff, coord_x_in;
   logic [15:0]           coord_y_ff, coord_y_in;
   logic [15:0]           pix_y;
   logic [ProdWidth-1:0]  prod_x, prod_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         display_height_ff <= '0;
         x_scale_ff        <= '0;
         y_scale_ff        <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_DISPLAY_HEIGHT: display_height_ff <= csr_data[15:0];
            CSR_X_SCALE:        x_scale_ff        <= csr_data[ScaleWidth-1:0];
            CSR_Y_SCALE:        y_scale_ff        <= csr_data[ScaleWidth-1:0];
            default: ;
         endcase
      end
   end

   // y is flipped against the display height, wrapping at 16 bits
   assign pix_y  = display_height_ff - pos_y;
   assign prod_x = ProdWidth'(pos_x) * ProdWidth'(x_scale_ff);
   assign prod_y = ProdWidth'(pix_y) * ProdWidth'(y_scale_ff);

   always_comb begin
      coord_x_in      = coord_x_ff;
      coord_y_in      = coord_y_ff;
      pressed_in      = pressed_ff;
      lift_pending_in = lift_pending_ff;
      if (touch_take) begin
         coord_x_in = prod_x[31:16];
         coord_y_in = prod_y[31:16];
         pressed_in = touch_down;
      end
      if (tick_take) begin
         if (pressed_ff) begin
            lift_pending_in = 1'b1;
         end else begin
            lift_pending_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_x_ff      <= '0;
         coord_y_ff      <= '0;
         pressed_ff      <= 1'b0;
         lift_pending_ff <= 1'b0;
      end else begin
         coord_x_ff      <= coord_x_in;
         coord_y_ff      <= coord_y_in;
         pressed_ff      <= pressed_in;
         lift_pending_ff <= lift_pending_in;
      end
   end

   assign status.pressed      = pressed_ff;
   assign status.lift_pending = lift_pending_ff;
   assign status.coord_x      = coord_x_ff;
   assign status.coord_y      = coord_y_ff;

endmodule

[src/stc_tx.sv]
module stc_tx
   import stc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  stc_pkt_type pkt,
   input  logic        rsp_stall,
   output logic        free,
   output logic        rsp_valid,
   output stc_rsp_type rsp_data
);

   stc_pkt_type            pkt_ff;
   logic                   valid_ff, valid_in;
   logic [PktIdxWidth-1:0] idx_ff, idx_in;
   logic                   at_last;
   logic                   beat_done;

   assign at_last   = (idx_ff == pkt_ff.last_idx);
   assign beat_done = valid_ff && !rsp_stall;
   // slot opens when empty or while its final beat leaves
   assign free      = !valid_ff || (beat_done && at_last);

   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (beat_done) begin
         if (at_last) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pkt_ff <= pkt;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_data.out_byte = pkt_ff.bytes[idx_ff];
   assign rsp_data.last     = at_last;

endmodule

[bench/tb_serial_touch_controller.sv]
`timescale 1ns / 100ps

module tb_serial_touch_controller;
   import stc_pkg::*;

   localparam int CycleLimit   = 200000;
   localparam int SettleCycles = 8;
   localparam int HoldCycles   = 300;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   typedef logic [7:0] byte_q[$];

   class touch_scoreboard;
      stc_rsp_type pending_bytes[$];
      int errors = 0;
      int beats_checked = 0;
      int acks = 0;
      int reports = 0;
      int requests = 0;

      logic [15:0] height = '0;
      logic [29:0] x_factor = '0;
      logic [29:0] y_factor = '0;
      bit booted = 1'b0;
      bit pressed = 1'b0;
      bit lift_pending = 1'b0;
      logic [15:0] coord_x = '0;
      logic [15:0] coord_y = '0;
      logic [7:0] cmd_buf[BufDepth];
      logic [LenWidth-1:0] cmd_len = '0;

      function void set_register(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] val);
         case (idx)
            CSR_DISPLAY_HEIGHT: height = val[15:0];
            CSR_X_SCALE:        x_factor = val;
            CSR_Y_SCALE:        y_factor = val;
            default: ;
         endcase
      endfunction

      function logic [15:0] scaled(logic [15:0] pix, logic [29:0] factor);
         logic [ProdWidth-1:0] prod;
         prod = pix * factor;
         return prod[31:16];
      endfunction

      function void expect_beat(logic [7:0] b, logic fin);
         stc_rsp_type e;
         e.out_byte = b;
         e.last = fin;
         pending_bytes.push_back(e);
      endfunction

      function void expect_report(logic [7:0] head);
         expect_beat(head, 1'b0);
         expect_beat({1'b0, coord_x[6:0]}, 1'b0);
         expect_beat({1'b0, coord_x[13:7]}, 1'b0);
         expect_beat({1'b0, coord_y[6:0]}, 1'b0);
         expect_beat({1'b0, coord_y[13:7]}, 1'b1);
         reports++;
      endfunction

      function void note_request(stc_req_type r);
         requests++;
         case (r.mode)
            MODE_HOST: begin
               if (r.host_byte != TERM_BYTE) begin
                  if (cmd_len < BufDepth)
                     cmd_buf[cmd_len] = r.host_byte;
                  if (cmd_len != LEN_MAX)
                     cmd_len++;
               end else begin
                  if (cmd_len == 2 && cmd_buf[0] == SOH_BYTE && cmd_buf[1] == CMD_RESTART)
                     booted = 1'b0;
                  else if (cmd_len == 3 && cmd_buf[0] == SOH_BYTE && cmd_buf[1] == CMD_DIAG &&
                           cmd_buf[2] == CMD_DIAG_X)
                     booted = 1'b1;
                  cmd_len = '0;
                  expect_beat(SOH_BYTE, 1'b0);
                  expect_beat(ACK_MID, 1'b0);
                  expect_beat(TERM_BYTE, 1'b1);
                  acks++;
               end
            end
            MODE_TOUCH: begin
               if (booted) begin
                  coord_x = scaled(r.pos_x, x_factor);
                  coord_y = scaled(height - r.pos_y, y_factor);
                  pressed = r.touch_down;
               end
            end
            MODE_TICK: begin
               if (pressed) begin
                  lift_pending = 1'b1;
                  expect_report(HEAD_PRESS);
               end else if (lift_pending) begin
                  lift_pending = 1'b0;
                  expect_report(HEAD_LIFT);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(stc_rsp_type got);
         stc_rsp_type want;
         if (pending_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual byte %h last %b",
                     $time, got.out_byte, got.last);
            return;
         end
         want = pending_bytes.pop_front();
         beats_checked++;
         if (got.out_byte !== want.out_byte) begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
         end
         if (got.last !== want.last) begin
            errors++;
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   stc_req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   stc_rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_data = '0;

   touch_scoreboard sb = new();
   bit steady = 1'b0;
   int hold_len = 0;
   int held = 0;
   int sent = 0;
   int cycles = 0;

   serial_touch_controller dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("%0t: timeout with %0d result beats outstanding", $time,
                  sb.pending_bytes.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver: random stall, or a long hold-off counted here
   always @(posedge clock) begin
      if (hold_len != 0 && held < hold_len) begin
         rsp_stall <= 1'b1;
         held <= held + 1;
      end else begin
         if (hold_len == 0)
            held <= 0;
         rsp_stall <= !steady && ($urandom_range(99) < 25);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_request(req_data);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_data);
      end
   end

   function automatic stc_req_type noise_fields(logic [1:0] mode);
      stc_req_type r;
      r.mode = mode;
      r.host_byte = 8'($urandom);
      r.pos_x = 16'($urandom);
      r.pos_y = 16'($urandom);
      r.touch_down = 1'($urandom);
      return r;
   endfunction

   function automatic logic [29:0] q16_ratio(int span);
      return 30'((64'd16383 << 16) / span);
   endfunction

   task automatic send_item(input stc_req_type item);
      if (!steady)
         while ($urandom_range(99) < 25) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (item.mode != MODE_UNUSED)
         sent++;
   endtask

   task automatic send_packet(input byte_q body);
      stc_req_type r;
      foreach (body[i]) begin
         r = noise_fields(MODE_HOST);
         r.host_byte = body[i];
         send_item(r);
      end
      r = noise_fields(MODE_HOST);
      r.host_byte = TERM_BYTE;
      send_item(r);
   endtask

   task automatic send_touch(input logic [15:0] x, input logic [15:0] y, input logic down);
      stc_req_type r;
      r = noise_fields(MODE_TOUCH);
      r.pos_x = x;
      r.pos_y = y;
      r.touch_down = down;
      send_item(r);
   endtask

   task automatic send_tick();
      send_item(noise_fields(MODE_TICK));
   endtask

   task automatic random_sequence();
      int pick;
      int len;
      logic [7:0] b;
      logic [15:0] x;
      logic [15:0] y;
      byte_q body;
      pick = $urandom_range(99);
      if (pick < 14) begin
         body = {SOH_BYTE, CMD_DIAG, CMD_DIAG_X};
         send_packet(body);
      end else if (pick < 20) begin
         body = {SOH_BYTE, CMD_RESTART};
         send_packet(body);
      end else if (pick < 30) begin
         len = $urandom_range(9);
         repeat (len) begin
            b = 8'($urandom);
            if (b == TERM_BYTE)
               b = ~b;
            body.push_back(b);
         end
         send_packet(body);
      end else if (pick < 36) begin
         // near misses of the two commands
         case ($urandom_range(3))
            0: body = {SOH_BYTE, CMD_RESTART, CMD_RESTART};
            1: body = {SOH_BYTE, CMD_DIAG};
            2: body = {SOH_BYTE, CMD_DIAG, CMD_DIAG_X, CMD_DIAG_X};
            default: body = {SOH_BYTE, CMD_DIAG_X, CMD_DIAG};
         endcase
         send_packet(body);
      end else if (pick < 66) begin
         x = 16'($urandom);
         y = 16'($urandom);
         if ($urandom_range(1) != 0) begin
            x = 16'($urandom_range(2047));
            y = 16'($urandom_range(2047));
         end
         send_touch(x, y, $urandom_range(3) != 0);
      end else if (pick < 95) begin
         send_tick();
      end else begin
         send_item(noise_fields(MODE_UNUSED));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_bytes.size() != 0)
         @(posedge clock);
      repeat (SettleCycles)
         @(posedge clock);
   endtask

   task automatic load_settings(input logic [15:0] height, input logic [29:0] xs,
                                input logic [29:0] ys);
      logic [CsrDataWidth-1:0] padded;
      padded = CsrDataWidth'($urandom);
      padded[15:0] = height;
      csr_wr_en <= 1'b1;
      csr_index <= CSR_DISPLAY_HEIGHT;
      csr_data <= padded;
      sb.set_register(CSR_DISPLAY_HEIGHT, padded);
      @(posedge clock);
      csr_index <= CSR_X_SCALE;
      csr_data <= xs;
      sb.set_register(CSR_X_SCALE, xs);
      @(posedge clock);
      csr_index <= CSR_Y_SCALE;
      csr_data <= ys;
      sb.set_register(CSR_Y_SCALE, ys);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int target;
      byte_q body;

      repeat (8)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      load_settings(16'd600, q16_ratio(800), q16_ratio(600));

      // nothing to report, touch before boot, unused mode, empty packet
      send_tick();
      send_touch(16'hffff, 16'hffff, 1'b1);
      send_item(noise_fields(MODE_UNUSED));
      body.delete();
      send_packet(body);
      body = {SOH_BYTE, CMD_DIAG, CMD_DIAG_X};
      send_packet(body);
      send_touch(16'hffff, 16'h0000, 1'b1);
      send_tick();
      send_touch(16'h0000, 16'hffff, 1'b0);
      send_tick();
      send_tick();
      body = {8'h00, 8'hff};
      send_packet(body);
      body = {SOH_BYTE, CMD_RESTART};
      send_packet(body);
      send_touch(16'h1234, 16'h0042, 1'b1);
      send_tick();

      // all-ones settings, no idling on either side
      wait_drained();
      load_settings('1, '1, '1);
      steady = 1'b1;
      target = sent + 50;
      while (sent < target)
         random_sequence();
      wait_drained();
      steady = 1'b0;

      // zero settings; receiver holds off while beats keep coming
      load_settings('0, '0, '0);
      body = {SOH_BYTE, CMD_DIAG, CMD_DIAG_X};
      hold_len = HoldCycles;
      send_packet(body);
      target = sent + 30;
      while (sent < target)
         random_sequence();
      // long packet saturates the length count and is only acknowledged
      body = {SOH_BYTE, CMD_DIAG, CMD_DIAG_X, 8'h00, 8'hff, 8'h11, 8'h22, 8'h33, 8'h44};
      send_packet(body);
      wait_drained();
      hold_len = 0;

      load_settings(16'($urandom), 30'($urandom), 30'($urandom));
      target = sent + 100;
      while (sent < target)
         random_sequence();
      wait_drained();

      if (sb.pending_bytes.size() != 0) begin
         sb.errors++;
         $display("%0t: %0d result beats expected but never seen", $time,
                  sb.pending_bytes.size());
      end

      $display("sent %0d request beats; checked %0d result beats (%0d acks, %0d reports)",
               sb.requests, sb.beats_checked, sb.acks, sb.reports);
      $display("settings: typical, all-ones, zero and random; one long receiver hold-off");
      if (sb.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[files.f]
src/stc_pkg.sv
src/stc_cmd.sv
src/stc_touch.sv
src/stc_tx.sv
src/serial_touch_controller.sv
bench/tb_serial_touch_controller.sv
